FILE: hdl/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package rhc_pkg;

   localparam int CH_W     = 8;
   localparam int HUE_W    = 9;
   localparam int QUOT_W   = 9;
   localparam int DEN_W    = 9;
   localparam int NUM_W    = QUOT_W + DEN_W;
   localparam int HUE_WRAP = 360;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rhc_req_type;

   typedef struct packed {
      logic [HUE_W-1:0] hue;
      logic [CH_W-1:0]  saturation;
      logic [CH_W-1:0]  brightness;
      logic             hue_held;
   } rhc_rsp_type;

   typedef struct packed {
      logic             held;
      logic [CH_W-1:0]  brightness;
      logic [NUM_W-1:0] sat_num;
      logic [DEN_W-1:0] sat_den;
      logic [NUM_W-1:0] hue_num;
      logic [DEN_W-1:0] hue_den;
   } rhc_prep_type;

   typedef struct packed {
      logic             start;
      logic [NUM_W-1:0] num;
      logic [DEN_W-1:0] den;
   } rhc_div_ctl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic [QUOT_W-1:0] quot;
   } rhc_div_stat_type;

endpackage

FILE: hdl/rhc_prep.sv
// Pixel front end: max/min, and the dividend/divisor pairs for both divisions.
module rhc_prep (
   input  logic                 clock,
   input  logic                 load,
   input  rhc_pkg::rhc_req_type pixel,
   output rhc_pkg::rhc_prep_type prep
);
   import rhc_pkg::*;

   localparam int WIDE_W    = NUM_W + 2;
   localparam int SAT_SCALE = 510;

   rhc_prep_type prep_ff, prep_in;
   logic [CH_W-1:0] mx, mn, d;
   logic signed [WIDE_W-1:0] rs, gs, bs, ds, num, hue_wide;

   always_comb begin
      mx = (pixel.red > pixel.green) ? pixel.red : pixel.green;
      if (pixel.blue > mx) begin
         mx = pixel.blue;
      end
      mn = (pixel.red < pixel.green) ? pixel.red : pixel.green;
      if (pixel.blue < mn) begin
         mn = pixel.blue;
      end
      d  = mx - mn;
      rs = $signed({{(WIDE_W-CH_W){1'b0}}, pixel.red});
      gs = $signed({{(WIDE_W-CH_W){1'b0}}, pixel.green});
      bs = $signed({{(WIDE_W-CH_W){1'b0}}, pixel.blue});
      ds = $signed({{(WIDE_W-CH_W){1'b0}}, d});

      // red wins ties, then green
      if (mx == pixel.red) begin
         num = WIDE_W'(60) * (gs - bs);
         if (num < 0) begin
            num = num + WIDE_W'(360) * ds;
         end
      end else if (mx == pixel.green) begin
         num = WIDE_W'(60) * (bs - rs) + WIDE_W'(120) * ds;
      end else begin
         num = WIDE_W'(60) * (rs - gs) + WIDE_W'(240) * ds;
      end
      hue_wide = (num <<< 1) + ds;

      prep_in.held       = (d == '0);
      prep_in.brightness = mx;
      prep_in.sat_num    = NUM_W'(d) * NUM_W'(SAT_SCALE) + NUM_W'(mx);
      prep_in.sat_den    = {mx, 1'b0};
      prep_in.hue_num    = hue_wide[NUM_W-1:0];
      prep_in.hue_den    = {d, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prep_ff <= prep_in;
      end
   end

   assign prep = prep_ff;

endmodule

FILE: hdl/rhc_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module rhc_divider (
   input  logic                      clock,
   input  logic                      reset,
   input  rhc_pkg::rhc_div_ctl_type  ctl,
   output rhc_pkg::rhc_div_stat_type stat
);
   import rhc_pkg::*;

   localparam int CNT_W = $clog2(QUOT_W);

   logic [DEN_W-1:0]  rem_ff, rem_in, den_ff, den_in;
   logic [QUOT_W-1:0] sh_ff, sh_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DEN_W:0]    trial, diff;
   logic              fits;

   always_comb begin
      trial = {rem_ff, sh_ff[QUOT_W-1]};
      diff  = trial - {1'b0, den_ff};
      fits  = (trial >= {1'b0, den_ff});

      rem_in  = rem_ff;
      sh_in   = sh_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         // quotient fits QUOT_W bits, so the top dividend bits start below the divisor
         rem_in  = ctl.num[NUM_W-1:QUOT_W];
         sh_in   = ctl.num[QUOT_W-1:0];
         den_in  = ctl.den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         sh_in  = {sh_ff[QUOT_W-2:0], fits};
         if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      den_ff <= den_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign stat.quot = sh_ff;

endmodule

FILE: hdl/rgb_to_hsv_converter.sv
// Top level of the RGB to HSV converter: sequencer, output register, checks.
// Converts one 8-bit RGB pixel to hue (0..359 degrees), saturation and value
// (0..255). One pixel is worked at a time: a new pixel is not taken until the
// last one is in the output register. For a colored pixel both the saturation
// and the hue fraction go through one shared bit-serial divider, one after the
// other, after a setup state. A black or gray pixel skips the divider; it
// returns the last computed hue with hue_held set and saturation 0. The result
// sits in an output register, so the next pixel may be taken while it waits.
module rgb_to_hsv_converter (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  rhc_pkg::rhc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rhc_pkg::rhc_rsp_type rsp_data
);
   import rhc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOAD,
      S_SAT,
      S_HUE,
      S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic             start_ff, start_in;
   logic [HUE_W-1:0] last_hue_ff, last_hue_in;
   logic [CH_W-1:0]  sat_ff, sat_in;
   logic             held_ff, held_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rhc_rsp_type      rsp_data_ff, rsp_data_in;

   rhc_prep_type     prep;
   rhc_div_ctl_type  div_ctl;
   rhc_div_stat_type div_stat;
   logic             req_xfer;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;

   rhc_prep u_prep (
      .clock (clock),
      .load  (req_xfer),
      .pixel (req_data),
      .prep  (prep)
   );

   always_comb begin
      div_ctl.start = start_ff;
      div_ctl.num   = (state_ff == S_HUE) ? prep.hue_num : prep.sat_num;
      div_ctl.den   = (state_ff == S_HUE) ? prep.hue_den : prep.sat_den;
   end

   rhc_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .stat  (div_stat)
   );

   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      last_hue_in  = last_hue_ff;
      sat_in       = sat_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // drop the result once transferred
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            held_in = prep.held;
            if (prep.held) begin
               sat_in   = '0;
               state_in = S_DONE;
            end else begin
               start_in = 1'b1;
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            if (div_stat.done) begin
               sat_in   = div_stat.quot[CH_W-1:0];
               start_in = 1'b1;
               state_in = S_HUE;
            end
         end
         S_HUE: begin
            if (div_stat.done) begin
               // a hue that rounds up to a full turn wraps to zero
               if (div_stat.quot == HUE_W'(HUE_WRAP)) begin
                  last_hue_in = '0;
               end else begin
                  last_hue_in = div_stat.quot;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.hue        = last_hue_ff;
               rsp_data_in.saturation = sat_ff;
               rsp_data_in.brightness = prep.brightness;
               rsp_data_in.hue_held   = held_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         last_hue_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         last_hue_ff  <= last_hue_in;
         sat_ff       <= sat_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_ctl.start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_done_state: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == S_SAT || state_ff == S_HUE))
      else $error("divider finished outside a division state");

   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.hue < HUE_W'(HUE_WRAP)))
      else $error("hue out of range");

   a_held_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.hue_held) |-> (rsp_data.saturation == '0))
      else $error("held hue with nonzero saturation");
`endif

endmodule
